### hdl/ugbi_pkg.sv
// Shared types and constants for the uniform-grid bilinear interpolation core.
// Word layouts of both stream channels, register indexes, and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps

package ugbi_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] CFG_INV_PITCH_X = 3'd2;
    localparam logic [2:0] CFG_INV_PITCH_Y = 3'd3;
    localparam logic [2:0] CFG_COLS_USED   = 3'd4;
    localparam logic [2:0] CFG_ROWS_USED   = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SIZE_W     = 7;

    // Request kinds carried in s_tuser
    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_LOAD  = 1'b1;

    // Input word layout, lowest bit first
    localparam int X_LSB     = 0;
    localparam int Y_LSB     = 32;
    localparam int COL_LSB   = 64;
    localparam int ROW_LSB   = 70;
    localparam int VAL_LSB   = 76;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 16;

    localparam int COORD_W  = 32;
    localparam int LDIDX_W  = 6;
    localparam int SAMPLE_W = 16;

    // Q1.16 fraction, 0..1.0 inclusive
    localparam int                FRAC_W   = 17;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h1_0000;

    // Blend accumulator and round-half-up bias in Q.32
    localparam int               BLEND_W    = 32;
    localparam int               V_W        = 49;
    localparam logic [V_W-1:0]   ROUND_BIAS = 49'h0_0000_8000_0000;

    // Per-axis result of the locate pipeline
    typedef struct packed {
        logic              clamped;
        logic [FRAC_W-1:0] frac;
    } axis_pos_t;

endpackage

### hdl/ugbi_bank.sv
// One sample bank: simple dual-port memory, one write and one registered read.
// Uses ugbi_pkg for the sample width.
`timescale 1ns / 1ps

module ugbi_bank
    import ugbi_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/ugbi_locate.sv
// Three-stage locate pipeline for one axis: offset, scale by reciprocal pitch,
// clamp to the last full cell and split into cell index and fraction. Uses ugbi_pkg.
`timescale 1ns / 1ps

module ugbi_locate
    import ugbi_pkg::*;
#(
    parameter int NW = 7,
    parameter int CW = 6
) (
    input  logic               aclk,
    input  logic               adv,
    input  logic [COORD_W-1:0] pos,
    input  logic [COORD_W-1:0] org,
    input  logic [COORD_W-1:0] inv,
    input  logic [NW-1:0]      n_eff,
    output logic [CW-1:0]      cell_idx,
    output axis_pos_t          info
);

    logic signed [COORD_W:0]     d_next;
    logic signed [COORD_W:0]     d_reg;
    logic [2*COORD_W-1:0]        p_next;
    logic [2*COORD_W-1:0]        p_reg;
    logic                        neg_reg;
    logic [COORD_W-1:0]          hi;
    logic [COORD_W-1:0]          lo;
    logic [COORD_W-1:0]          nm1;
    logic                        at_top;
    logic                        over;
    logic [CW-1:0]               cell_next;
    logic [CW-1:0]               cell_reg;
    axis_pos_t                   info_next;
    axis_pos_t                   info_reg;

    // Stage 1: offset from the origin, 33-bit signed
    assign d_next = $signed({pos[COORD_W-1], pos}) - $signed({org[COORD_W-1], org});

    // Stage 2: grid position in Q32.32
    assign p_next = (2*COORD_W)'(d_reg[COORD_W-1:0]) * (2*COORD_W)'(inv);

    // Stage 3: clamp to the near and far edges and split cell / fraction
    assign hi     = p_reg[2*COORD_W-1:COORD_W];
    assign lo     = p_reg[COORD_W-1:0];
    assign nm1    = COORD_W'(n_eff) - COORD_W'(1);
    assign at_top = (hi >= nm1);
    assign over   = (hi > nm1) || ((hi == nm1) && (lo != '0));

    always_comb begin
        if (neg_reg) begin
            cell_next         = '0;
            info_next.frac    = '0;
            info_next.clamped = 1'b1;
        end else if (at_top) begin
            cell_next         = CW'(n_eff - NW'(2));
            info_next.frac    = FRAC_ONE;
            info_next.clamped = over;
        end else begin
            cell_next         = hi[CW-1:0];
            info_next.frac    = {1'b0, lo[COORD_W-1:COORD_W-16]};
            info_next.clamped = 1'b0;
        end
    end

    // Advance all three stages together
    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg    <= d_next;
            p_reg    <= p_next;
            neg_reg  <= d_reg[COORD_W];
            cell_reg <= cell_next;
            info_reg <= info_next;
        end
    end

    assign cell_idx = cell_reg;
    assign info     = info_reg;

endmodule

### hdl/uniform_grid_bilinear_interp_core.sv
// Top level of the uniform-grid bilinear interpolation core.
// Depends on ugbi_pkg, ugbi_locate and ugbi_bank.
`timescale 1ns / 1ps

// The core takes one word per cycle, query or sample load, while no result
// word waits on m_tready, and returns one result word per query; loads give
// no result. The pipeline is: origin subtract, 32x32 scale by reciprocal
// pitch, clamp and cell/fraction split, sample read from four banks (split by
// row and column parity so the four corners of any cell come out in the same
// cycle), two blend multiply stages, and the rounding output register. A load
// writes its bank at the same stage where queries read, so every query sees
// all loads that were accepted ahead of it. The whole pipeline holds while a
// result word waits on m_tready, and resumes without loss. Samples never
// loaded read as undefined.
module uniform_grid_bilinear_interp_core
    import ugbi_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] x_pos, [63:32] y_pos, [69:64] load_col, [75:70] load_row,
    // [91:76] load_value, [95:92] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] req_type
    input  logic                  s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] interp_value
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] clamped
    output logic                  m_tuser
);

    localparam int CXW = $clog2(MAX_COLS);
    localparam int CYW = $clog2(MAX_ROWS);
    localparam int NXW = ($clog2(MAX_COLS + 1) > SIZE_W) ? $clog2(MAX_COLS + 1) : SIZE_W;
    localparam int NYW = ($clog2(MAX_ROWS + 1) > SIZE_W) ? $clog2(MAX_ROWS + 1) : SIZE_W;
    localparam int HC  = (MAX_COLS + 1) / 2;
    localparam int HR  = (MAX_ROWS + 1) / 2;
    localparam int BD  = HR * HC;
    localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
    localparam int NST = 6;

    typedef struct packed {
        logic                ok;
        logic [1:0]          bank;
        logic [BAW-1:0]      addr;
        logic [SAMPLE_W-1:0] value;
    } load_t;

    // configuration registers
    logic [COORD_W-1:0] origin_x_reg;
    logic [COORD_W-1:0] origin_y_reg;
    logic [COORD_W-1:0] inv_pitch_x_reg;
    logic [COORD_W-1:0] inv_pitch_y_reg;
    logic [SIZE_W-1:0]  cols_used_reg;
    logic [SIZE_W-1:0]  rows_used_reg;

    logic [NXW-1:0] cols_ext;
    logic [NYW-1:0] rows_ext;
    logic [NXW-1:0] n_cols;
    logic [NYW-1:0] n_rows;

    logic           adv;
    logic [NST-1:0] pipe_valid_reg;
    logic [NST-1:0] is_load_reg;

    logic [LDIDX_W-1:0] ld_col;
    logic [LDIDX_W-1:0] ld_row;
    load_t              ld_next;
    load_t              ld1_reg;
    load_t              ld2_reg;
    load_t              ld3_reg;

    logic [CXW-1:0] cell_x;
    logic [CYW-1:0] cell_y;
    axis_pos_t      loc_x;
    axis_pos_t      loc_y;

    logic [SAMPLE_W-1:0] bank_q [4];
    logic [3:0]          bank_we;

    logic              cxp4_reg;
    logic              cyp4_reg;
    logic [FRAC_W-1:0] fx4_reg;
    logic [FRAC_W-1:0] fy4_reg;
    logic              clamped4_reg;

    logic signed [SAMPLE_W-1:0] s00;
    logic signed [SAMPLE_W-1:0] s01;
    logic signed [SAMPLE_W-1:0] s10;
    logic signed [SAMPLE_W-1:0] s11;
    logic signed [FRAC_W:0]     wx0;
    logic signed [FRAC_W:0]     wx1;
    logic signed [33:0]         pa0;
    logic signed [33:0]         pa1;
    logic signed [33:0]         pb0;
    logic signed [33:0]         pb1;
    logic signed [BLEND_W-1:0]  a_next;
    logic signed [BLEND_W-1:0]  b_next;
    logic signed [BLEND_W-1:0]  a_reg;
    logic signed [BLEND_W-1:0]  b_reg;
    logic [FRAC_W-1:0]          fy5_reg;
    logic                       clamped5_reg;

    logic signed [FRAC_W:0]  wy0;
    logic signed [FRAC_W:0]  wy1;
    logic signed [49:0]      pv0;
    logic signed [49:0]      pv1;
    logic [V_W-1:0]          v_next;
    logic [V_W-1:0]          v_reg;
    logic                    clamped6_reg;

    logic [V_W-1:0]          rnd;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    logic                    m_tuser_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            inv_pitch_x_reg <= 32'h0001_0000;
            inv_pitch_y_reg <= 32'h0001_0000;
            cols_used_reg   <= 7'd64;
            rows_used_reg   <= 7'd64;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_ORIGIN_X:    origin_x_reg    <= cfg_wr_data;
                CFG_ORIGIN_Y:    origin_y_reg    <= cfg_wr_data;
                CFG_INV_PITCH_X: inv_pitch_x_reg <= cfg_wr_data;
                CFG_INV_PITCH_Y: inv_pitch_y_reg <= cfg_wr_data;
                CFG_COLS_USED:   cols_used_reg   <= cfg_wr_data[SIZE_W-1:0];
                CFG_ROWS_USED:   rows_used_reg   <= cfg_wr_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Limit the grid size to 2..MAX
    assign cols_ext = NXW'(cols_used_reg);
    assign rows_ext = NYW'(rows_used_reg);

    always_comb begin
        if (cols_ext < NXW'(2)) begin
            n_cols = NXW'(2);
        end else if (cols_ext > NXW'(MAX_COLS)) begin
            n_cols = NXW'(MAX_COLS);
        end else begin
            n_cols = cols_ext;
        end
        if (rows_ext < NYW'(2)) begin
            n_rows = NYW'(2);
        end else if (rows_ext > NYW'(MAX_ROWS)) begin
            n_rows = NYW'(MAX_ROWS);
        end else begin
            n_rows = rows_ext;
        end
    end

    // Hold everything while a result word waits
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Valid bits travel with the words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= '0;
            is_load_reg    <= '0;
        end else if (adv) begin
            pipe_valid_reg <= {pipe_valid_reg[NST-2:0], s_tvalid};
            is_load_reg    <= {is_load_reg[NST-2:0], (s_tuser == REQ_LOAD)};
        end
    end

    // Decode a load word: bank by parity, address by half indexes
    assign ld_col        = s_tdata[COL_LSB +: LDIDX_W];
    assign ld_row        = s_tdata[ROW_LSB +: LDIDX_W];
    assign ld_next.ok    = (32'(ld_col) < 32'(MAX_COLS)) && (32'(ld_row) < 32'(MAX_ROWS));
    assign ld_next.bank  = {ld_row[0], ld_col[0]};
    assign ld_next.addr  = BAW'(BAW'(ld_row[LDIDX_W-1:1]) * BAW'(HC))
                         + BAW'(ld_col[LDIDX_W-1:1]);
    assign ld_next.value = s_tdata[VAL_LSB +: SAMPLE_W];

    // Carry load words down to the memory stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            ld1_reg <= ld_next;
            ld2_reg <= ld1_reg;
            ld3_reg <= ld2_reg;
        end
    end

    // Stages 1..3: locate each axis
    ugbi_locate #(
        .NW (NXW),
        .CW (CXW)
    ) u_loc_x (
        .aclk     (aclk),
        .adv      (adv),
        .pos      (s_tdata[X_LSB +: COORD_W]),
        .org      (origin_x_reg),
        .inv      (inv_pitch_x_reg),
        .n_eff    (n_cols),
        .cell_idx (cell_x),
        .info     (loc_x)
    );

    ugbi_locate #(
        .NW (NYW),
        .CW (CYW)
    ) u_loc_y (
        .aclk     (aclk),
        .adv      (adv),
        .pos      (s_tdata[Y_LSB +: COORD_W]),
        .org      (origin_y_reg),
        .inv      (inv_pitch_y_reg),
        .n_eff    (n_rows),
        .cell_idx (cell_y),
        .info     (loc_y)
    );

    // Stage 4: four parity banks, one corner each
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam bit RP = ((b / 2) != 0);
        localparam bit CP = ((b % 2) != 0);

        logic [CYW-1:0] ry;
        logic [CXW-1:0] rx;
        logic [BAW-1:0] rd_addr;

        // Odd bank takes cell>>1, even bank takes (cell+1)>>1
        assign ry      = (RP ? cell_y : (cell_y + CYW'(1))) >> 1;
        assign rx      = (CP ? cell_x : (cell_x + CXW'(1))) >> 1;
        assign rd_addr = BAW'(BAW'(ry) * BAW'(HC)) + BAW'(rx);
        assign bank_we[b] = adv && pipe_valid_reg[2] && is_load_reg[2]
                         && ld3_reg.ok && (ld3_reg.bank == 2'(b));

        ugbi_bank #(
            .DEPTH (BD),
            .AW    (BAW)
        ) u_bank (
            .aclk    (aclk),
            .wr_en   (bank_we[b]),
            .wr_addr (ld3_reg.addr),
            .wr_data (ld3_reg.value),
            .rd_en   (adv),
            .rd_addr (rd_addr),
            .rd_data (bank_q[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cxp4_reg     <= cell_x[0];
            cyp4_reg     <= cell_y[0];
            fx4_reg      <= loc_x.frac;
            fy4_reg      <= loc_y.frac;
            clamped4_reg <= loc_x.clamped || loc_y.clamped;
        end
    end

    // Stage 5: route banks to corners, blend along x
    assign s00 = $signed(bank_q[{cyp4_reg, cxp4_reg}]);
    assign s01 = $signed(bank_q[{cyp4_reg, !cxp4_reg}]);
    assign s10 = $signed(bank_q[{!cyp4_reg, cxp4_reg}]);
    assign s11 = $signed(bank_q[{!cyp4_reg, !cxp4_reg}]);
    assign wx0 = $signed({1'b0, FRAC_ONE - fx4_reg});
    assign wx1 = $signed({1'b0, fx4_reg});
    assign pa0 = 34'(s00) * 34'(wx0);
    assign pa1 = 34'(s01) * 34'(wx1);
    assign pb0 = 34'(s10) * 34'(wx0);
    assign pb1 = 34'(s11) * 34'(wx1);
    assign a_next = BLEND_W'(pa0 + pa1);
    assign b_next = BLEND_W'(pb0 + pb1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg        <= a_next;
            b_reg        <= b_next;
            fy5_reg      <= fy4_reg;
            clamped5_reg <= clamped4_reg;
        end
    end

    // Stage 6: blend along y, Q.32
    assign wy0    = $signed({1'b0, FRAC_ONE - fy5_reg});
    assign wy1    = $signed({1'b0, fy5_reg});
    assign pv0    = 50'(a_reg) * 50'(wy0);
    assign pv1    = 50'(b_reg) * 50'(wy1);
    assign v_next = V_W'(pv0 + pv1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            v_reg        <= v_next;
            clamped6_reg <= clamped5_reg;
        end
    end

    // Output register: round half up, drop load words
    assign rnd = v_reg + ROUND_BIAS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= pipe_valid_reg[NST-1] && !is_load_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= rnd[47:32];
            m_tuser_reg <= clamped6_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // At most one bank takes a load in any cycle
    a_bank_we_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(bank_we))
        else $error("more than one sample bank written in one cycle");

    // Located cells stay inside the last full cell
    a_cell_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_valid_reg[2] && !is_load_reg[2]) |-> (NXW'(cell_x) <= n_cols - NXW'(2)))
        else $error("column cell beyond last full cell");

    a_cell_y_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_valid_reg[2] && !is_load_reg[2]) |-> (NYW'(cell_y) <= n_rows - NYW'(2)))
        else $error("row cell beyond last full cell");

    // Fractions never exceed one
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_valid_reg[2] && !is_load_reg[2])
            |-> ((loc_x.frac <= FRAC_ONE) && (loc_y.frac <= FRAC_ONE)))
        else $error("fraction above one");

endmodule

### bench/tb_uniform_grid_bilinear_interp_core.sv
// Self-checking bench for uniform_grid_bilinear_interp_core: sample loads and point queries
// on the input stream, predicted results checked in order on the result stream.
// Depends on ugbi_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_uniform_grid_bilinear_interp_core
    import ugbi_pkg::*;
();

    localparam int GRID_COLS      = 64;
    localparam int GRID_ROWS      = 64;
    localparam int FILL_SIZE      = 16;
    localparam int LATENCY        = 7;
    localparam int SETTLE         = LATENCY + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SET  = 120;

    // register indexes the core does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

    localparam logic [COORD_W-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [COORD_W-1:0] Q_HALF = 32'h0000_8000;

    // Predicts the core: sample table, register copy, and the queue of results owed.
    class interp_scoreboard;
        typedef struct {
            logic [SAMPLE_W-1:0] value;
            logic                clamped;
        } interp_result_t;

        logic [SAMPLE_W-1:0]   grid [GRID_ROWS*GRID_COLS];
        logic [COORD_W-1:0]    origin_x, origin_y, inv_pitch_x, inv_pitch_y;
        logic [SIZE_W-1:0]     cols_used, rows_used;
        interp_result_t        owed_results[$];
        int                    errors;

        function new();
            origin_x    = '0;
            origin_y    = '0;
            inv_pitch_x = 32'h0001_0000;
            inv_pitch_y = 32'h0001_0000;
            cols_used   = 7'd64;
            rows_used   = 7'd64;
            errors      = 0;
            foreach (grid[i]) grid[i] = '0;
        endfunction

        function int unsigned grid_extent(logic [SIZE_W-1:0] n, int unsigned maxn);
            if (n < 2) return 2;
            if (n > maxn) return maxn;
            return 32'(n);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ORIGIN_X:    origin_x    = data;
                CFG_ORIGIN_Y:    origin_y    = data;
                CFG_INV_PITCH_X: inv_pitch_x = data;
                CFG_INV_PITCH_Y: inv_pitch_y = data;
                CFG_COLS_USED:   cols_used   = data[SIZE_W-1:0];
                CFG_ROWS_USED:   rows_used   = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // Map one coordinate to a cell index and a Q1.16 fraction; flag points off the grid.
        function void locate_axis(input logic [COORD_W-1:0] pos, input logic [COORD_W-1:0] org,
                                  input logic [COORD_W-1:0] inv, input int unsigned n,
                                  output int unsigned cell_idx,
                                  output logic [FRAC_W-1:0] frac,
                                  output logic off_grid);
            longint      d;
            logic [63:0] p, lim, c;
            d        = longint'(signed'(pos)) - longint'(signed'(org));
            lim      = 64'(n - 1) << 32;
            off_grid = 1'b0;
            if (d < 0) begin
                p        = '0;
                off_grid = 1'b1;
            end else begin
                p = unsigned'(d) * {32'b0, inv};
                if (p > lim) begin
                    p        = lim;
                    off_grid = 1'b1;
                end
            end
            c = p >> 32;
            if (c > 64'(n - 2)) c = 64'(n - 2);
            cell_idx = int'(c);
            frac     = FRAC_W'((p - (c << 32)) >> 16);
        endfunction

        function interp_result_t blend_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            interp_result_t   r;
            int unsigned      cx, cy, base;
            logic [FRAC_W-1:0] fx, fy;
            logic             ox, oy;
            longint           s00, s01, s10, s11, a, b, v;
            locate_axis(x, origin_x, inv_pitch_x, grid_extent(cols_used, GRID_COLS), cx, fx, ox);
            locate_axis(y, origin_y, inv_pitch_y, grid_extent(rows_used, GRID_ROWS), cy, fy, oy);
            base = cy * GRID_COLS + cx;
            s00  = longint'(signed'(grid[base]));
            s01  = longint'(signed'(grid[base + 1]));
            s10  = longint'(signed'(grid[base + GRID_COLS]));
            s11  = longint'(signed'(grid[base + GRID_COLS + 1]));
            a = s00 * (65536 - longint'(fx)) + s01 * longint'(fx);
            b = s10 * (65536 - longint'(fx)) + s11 * longint'(fx);
            v = a * (65536 - longint'(fy)) + b * longint'(fy);
            // round half up: add one half in Q.32, then floor
            v = (v + (longint'(1) << 31)) >>> 32;
            r.value   = v[SAMPLE_W-1:0];
            r.clamped = ox | oy;
            return r;
        endfunction

        // Store a load, or queue the result a query is owed.
        function void note_word(logic kind, logic [S_TDATA_W-1:0] data);
            int unsigned col, row;
            if (kind == REQ_LOAD) begin
                col = 32'(data[COL_LSB +: LDIDX_W]);
                row = 32'(data[ROW_LSB +: LDIDX_W]);
                if (col < GRID_COLS && row < GRID_ROWS)
                    grid[row * GRID_COLS + col] = data[VAL_LSB +: SAMPLE_W];
            end else begin
                owed_results.insert(owed_results.size(),
                                    blend_point(data[X_LSB +: COORD_W],
                                                data[Y_LSB +: COORD_W]));
            end
        endfunction

        function void report(string what, longint e, longint a);
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, what, e, a);
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] data, logic flag);
            interp_result_t e;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: result word with none owed, expected nothing, got %0d",
                         $time, $signed(data[SAMPLE_W-1:0]));
                return;
            end
            e = owed_results.pop_front();
            if (data[SAMPLE_W-1:0] !== e.value)
                report("interp_value", $signed(e.value), $signed(data[SAMPLE_W-1:0]));
            if (flag !== e.clamped)
                report("clamped", e.clamped, flag);
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    interp_scoreboard sb;
    bit               tx_burst;
    bit               rx_burst;
    int               stall_cycles;

    uniform_grid_bilinear_interp_core #(
        .MAX_COLS(GRID_COLS),
        .MAX_ROWS(GRID_ROWS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Observe every handshake and register write at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
        if (aresetn && cfg_wr_en) sb.write_reg(cfg_wr_index, cfg_wr_data);
    end

    // Count cycles with no traffic at all.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        stall_cycles = 0;
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("uniform_grid_bilinear_interp_core: mismatch");
        $finish;
    end

    // Result side: wait a random number of cycles before taking each word.
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        rx_burst = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_burst = ($urandom_range(0, 2) == 0);
            gap = rx_burst ? 0 : $urandom_range(0, 9);
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic logic [S_TDATA_W-1:0] load_word(logic [LDIDX_W-1:0] col,
                                                       logic [LDIDX_W-1:0] row,
                                                       logic [SAMPLE_W-1:0] value);
        logic [S_TDATA_W-1:0] w;
        w = '0;
        w[COL_LSB +: LDIDX_W]  = col;
        w[ROW_LSB +: LDIDX_W]  = row;
        w[VAL_LSB +: SAMPLE_W] = value;
        return w;
    endfunction

    function automatic logic [S_TDATA_W-1:0] query_word(logic [COORD_W-1:0] x,
                                                        logic [COORD_W-1:0] y);
        logic [S_TDATA_W-1:0] w;
        w = '0;
        w[X_LSB +: COORD_W] = x;
        w[Y_LSB +: COORD_W] = y;
        return w;
    endfunction

    // Pick a coordinate: mostly inside the grid, some near either edge, some anywhere.
    function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] org,
                                                      logic [COORD_W-1:0] inv,
                                                      int unsigned n);
        logic [63:0]        span;
        logic [COORD_W-1:0] d;
        int unsigned        pick;
        if (inv == 0) span = 64'hFFFF_FFFF;
        else span = (64'(n - 1) << 32) / inv;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        pick = $urandom_range(0, 99);
        if (pick < 70) d = $urandom_range(0, span[31:0]);
        else if (pick < 80) d = span[31:0] + $urandom_range(0, 4) - 2;
        else if (pick < 88) d = $urandom_range(0, 4) - 2;
        else return $urandom;
        return org + d;
    endfunction

    // Present one word after a random gap and hold it until it is taken.
    task automatic send_word(logic kind, logic [S_TDATA_W-1:0] data);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait until every owed result is back and the pipe is empty.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
    endtask

    // Write all registers, plus one index the core does not decode.
    task automatic program_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] ipx,
                                logic [31:0] ipy, logic [31:0] nc, logic [31:0] nr);
        put_reg(CFG_ORIGIN_X, ox);
        put_reg(CFG_ORIGIN_Y, oy);
        put_reg(CFG_INV_PITCH_X, ipx);
        put_reg(CFG_INV_PITCH_Y, ipy);
        put_reg(CFG_COLS_USED, nc);
        put_reg(CFG_ROWS_USED, nr);
        put_reg($urandom_range(0, 1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B, $urandom);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random mix of sample loads and queries under the current setting.
    task automatic random_items(int count);
        int unsigned nc, nr;
        nc = sb.grid_extent(sb.cols_used, GRID_COLS);
        nr = sb.grid_extent(sb.rows_used, GRID_ROWS);
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 30) begin
                send_word(REQ_LOAD, load_word(LDIDX_W'($urandom), LDIDX_W'($urandom),
                                              SAMPLE_W'($urandom)));
            end else begin
                send_word(REQ_QUERY,
                          query_word(pick_coord(sb.origin_x, sb.inv_pitch_x, nc),
                                     pick_coord(sb.origin_y, sb.inv_pitch_y, nr)));
            end
        end
    endtask

    initial begin
        sb           = new();
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = REQ_QUERY;
        tx_burst     = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // fill the low corner plus the first two rows and columns; every query
        // below stays inside these samples or the far corner loaded next
        for (int r = 0; r < GRID_ROWS; r++)
            for (int c = 0; c < GRID_COLS; c++)
                if ((r < FILL_SIZE && c < FILL_SIZE) || r < 2 || c < 2)
                    send_word(REQ_LOAD, load_word(LDIDX_W'(c), LDIDX_W'(r),
                                                  SAMPLE_W'($urandom)));

        // directed: sample extremes, exact corners, ties, far edge, points off the grid
        send_word(REQ_LOAD, load_word(0, 0, 16'h7FFF));
        send_word(REQ_LOAD, load_word(1, 0, 16'h8000));
        send_word(REQ_LOAD, load_word(0, 1, 16'h0001));
        send_word(REQ_LOAD, load_word(1, 1, 16'h0000));
        send_word(REQ_LOAD, load_word(63, 63, 16'h8000));
        send_word(REQ_LOAD, load_word(62, 63, 16'h7FFF));
        send_word(REQ_LOAD, load_word(63, 62, 16'h5555));
        send_word(REQ_LOAD, load_word(62, 62, 16'hAAAA));
        send_word(REQ_QUERY, query_word(32'h0, 32'h0));
        send_word(REQ_QUERY, query_word(Q_ONE, 32'h0));
        send_word(REQ_QUERY, query_word(Q_HALF, 32'h0));
        send_word(REQ_QUERY, query_word(32'h0, Q_HALF));
        send_word(REQ_QUERY, query_word(Q_HALF, Q_HALF));
        send_word(REQ_QUERY, query_word(32'h003F_0000, 32'h003F_0000));
        send_word(REQ_QUERY, query_word(32'h003E_8000, 32'h003F_0000));
        send_word(REQ_QUERY, query_word(32'h003F_0001, 32'h003F_0000));
        send_word(REQ_QUERY, query_word(32'hFFFF_FFFF, 32'h0));
        send_word(REQ_QUERY, query_word(32'h7FFF_FFFF, 32'h8000_0000));
        send_word(REQ_QUERY, query_word(32'h8000_0000, 32'h7FFF_FFFF));
        send_word(REQ_QUERY, query_word(32'h003E_8000, 32'h003E_8000));
        drain();

        // offset origin, unequal pitches
        program_grid(32'hFFF6_0000, 32'h0005_4000, 32'h0002_0000, 32'h0000_8000,
                     FILL_SIZE, FILL_SIZE);
        random_items(ITEMS_PER_SET);
        drain();

        // smallest grid
        program_grid(32'h0, 32'h0, Q_ONE, Q_ONE, 2, 2);
        random_items(ITEMS_PER_SET);
        drain();

        // sizes below range, zero and full-scale reciprocal pitch
        program_grid(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'hFFFF_FFFF, 0, 1);
        random_items(ITEMS_PER_SET);
        drain();

        // column count above range, origin at both extremes
        program_grid(32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(32'h8000, 32'h2_0000),
                     $urandom_range(32'h8000, 32'h2_0000), 127, 2);
        random_items(ITEMS_PER_SET);
        drain();

        // row count above range
        program_grid(32'h7FFF_FFFF, 32'h8000_0000, $urandom_range(32'h8000, 32'h2_0000),
                     $urandom_range(32'h8000, 32'h2_0000), 2, 100);
        random_items(ITEMS_PER_SET);
        drain();

        // random settings; spare bits above the size field set at random
        for (int k = 0; k < 2; k++) begin
            program_grid($urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                         $urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                         $urandom_range(32'h4000, 32'h4_0000),
                         $urandom_range(32'h4000, 32'h4_0000),
                         ($urandom & 32'hFFFF_FF80) | $urandom_range(2, FILL_SIZE),
                         ($urandom & 32'hFFFF_FF80) | $urandom_range(2, FILL_SIZE));
            random_items(ITEMS_PER_SET);
            drain();
        end

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("uniform_grid_bilinear_interp_core: match");
        end else begin
            $display("uniform_grid_bilinear_interp_core: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
hdl/ugbi_pkg.sv
hdl/ugbi_bank.sv
hdl/ugbi_locate.sv
hdl/uniform_grid_bilinear_interp_core.sv
bench/tb_uniform_grid_bilinear_interp_core.sv
